/* rtl/core/bba_pkg.sv */
// Shared types and constants for the bitmap block allocator.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package bba_pkg;

  localparam int ROW_BITS    = 32;  // map flags per memory row
  localparam int ROW_BIT_W   = 5;   // bit position within a row
  localparam int ADDR_W      = 32;
  localparam int INDEX_OUT_W = 7;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } bba_op_e;

  typedef enum logic [2:0] {
    ST_ALLOCATED     = 3'd0,
    ST_OUT_OF_MEMORY = 3'd1,
    ST_FREED         = 3'd2,
    ST_NULL          = 3'd3,
    ST_OUTSIDE       = 3'd4
  } bba_status_e;

  typedef struct packed {
    bba_op_e             operation;
    logic [ADDR_W-1:0]   free_address;
  } bba_req_t;

  typedef struct packed {
    bba_status_e            status;
    logic [INDEX_OUT_W-1:0] block_index;
    logic [ADDR_W-1:0]      block_address;
  } bba_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ALLOC_PICK,
    S_ALLOC_ADDR,
    S_FREE_MUL,
    S_FREE_DIV,
    S_FREE_READ,
    S_FREE_WRITE
  } bba_state_e;

  // controller -> datapath
  typedef struct packed {
    logic        cap_req;
    logic        alloc_rd;
    logic        alloc_wr;
    logic        free_off;
    logic        free_mul;
    logic        free_div;
    logic        free_rd;
    logic        free_wr;
    logic        res_load;
    bba_status_e res_status;
  } bba_cmd_t;

  // datapath -> controller
  typedef struct packed {
    bba_op_e op;
    logic    any_free;
    logic    is_null;
    logic    outside;
  } bba_stat_t;

endpackage

/* rtl/core/bitmap_block_allocator.sv */
// Bitmap block allocator: allocate after accept runs row read, flag update and
// address, then the result strobe. Free runs offset, multiply, divide correction,
// row read and write. Out of memory, null and outside are decided at the check.
// One transaction at a time; start is accepted again while its result strobe is high.
// Reset clears base and all row valid/full flags; no memory sweep is needed.
`timescale 1ns / 1ps

module bitmap_block_allocator import bba_pkg::*; #(
  parameter int NUM_BLOCKS  = 128,
  parameter int BLOCK_BYTES = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  bba_req_t          req_i,
  output logic              done_o,
  output bba_rsp_t          rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [ADDR_W-1:0] cfg_data_i
);

  bba_cmd_t  cmd;
  bba_stat_t stat;

  assign cfg_ready_o = ~busy;

  bba_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  bba_dp #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .rsp_o      (rsp_o)
  );

endmodule

/* rtl/core/bba_ctrl.sv */
// Sequencer for the bitmap block allocator: walks one transaction through
// the datapath steps. Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_ctrl import bba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  bba_stat_t stat_i,
  output bba_cmd_t  cmd_o,
  output logic      busy_o,
  output logic      done_o
);

  bba_state_e state_q, state_d;
  logic       done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_status = ST_ALLOCATED;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.cap_req = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.op == OP_ALLOC) begin
          if (stat_i.any_free) begin
            cmd_o.alloc_rd = 1'b1;
            state_d        = S_ALLOC_PICK;
          end else begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ST_OUT_OF_MEMORY;
            state_d          = S_IDLE;
          end
        end else if (stat_i.is_null) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_NULL;
          state_d          = S_IDLE;
        end else if (stat_i.outside) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_OUTSIDE;
          state_d          = S_IDLE;
        end else begin
          cmd_o.free_off = 1'b1;
          state_d        = S_FREE_MUL;
        end
      end
      S_ALLOC_PICK: begin
        cmd_o.alloc_wr = 1'b1;
        state_d        = S_ALLOC_ADDR;
      end
      S_ALLOC_ADDR: begin
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = ST_ALLOCATED;
        state_d          = S_IDLE;
      end
      S_FREE_MUL: begin
        cmd_o.free_mul = 1'b1;
        state_d        = S_FREE_DIV;
      end
      S_FREE_DIV: begin
        cmd_o.free_div = 1'b1;
        state_d        = S_FREE_READ;
      end
      S_FREE_READ: begin
        cmd_o.free_rd = 1'b1;
        state_d       = S_FREE_WRITE;
      end
      S_FREE_WRITE: begin
        cmd_o.free_wr    = 1'b1;
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = ST_FREED;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    done_d = cmd_o.res_load;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

/* rtl/core/bba_dp.sv */
// Datapath of the bitmap block allocator: base register, usage map memory
// with per-row valid/full flags, constant divider, result register.
// Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_dp import bba_pkg::*; #(
  parameter int NUM_BLOCKS  = 128,
  parameter int BLOCK_BYTES = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ADDR_W-1:0] cfg_data_i,
  input  bba_req_t          req_i,
  input  bba_cmd_t          cmd_i,
  output bba_stat_t         stat_o,
  output bba_rsp_t          rsp_o
);

  localparam int NUM_ROWS = (NUM_BLOCKS + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int BLK_W    = ROW_W + ROW_BIT_W;
  localparam int LAST_CNT = NUM_BLOCKS - (NUM_ROWS - 1) * ROW_BITS;
  localparam int SPAN     = NUM_BLOCKS * BLOCK_BYTES;
  localparam int OFF_W    = $clog2(SPAN);
  localparam int RECIP_W  = OFF_W + 1;
  localparam int PROD_W   = OFF_W + RECIP_W;
  // floor(2^OFF_W / BLOCK_BYTES): estimate is exact or one low
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** OFF_W) / BLOCK_BYTES);

  logic [ADDR_W-1:0]   base_q;
  bba_req_t            req_q;
  logic [OFF_W-1:0]    off_q;
  logic [PROD_W-1:0]   prod_q;
  logic [BLK_W-1:0]    idx_q;
  logic [ROW_BITS-1:0] map_mem [NUM_ROWS];
  logic [NUM_ROWS-1:0] row_vld_q, row_full_q;
  logic [ROW_BITS-1:0] rd_q;
  logic                rd_vld_q;
  bba_rsp_t            rsp_q;

  logic [ADDR_W-1:0]    offset_full;
  logic [ROW_W-1:0]     first_row, rd_addr, idx_row;
  logic [ROW_BIT_W-1:0] idx_bit, free_bit;
  logic [ROW_BITS-1:0]  row_data, pad_mask, row_taken, wr_data;
  logic                 new_full;
  logic [BLK_W-1:0]     q_est, q_fix;
  logic [OFF_W-1:0]     rem;
  logic [ADDR_W-1:0]    alloc_addr;

  assign offset_full = req_q.free_address - base_q;
  assign idx_row     = idx_q[BLK_W-1:ROW_BIT_W];
  assign idx_bit     = idx_q[ROW_BIT_W-1:0];
  assign row_data    = rd_vld_q ? rd_q : '0;

  always_comb begin
    first_row = '0;
    for (int r = NUM_ROWS - 1; r >= 0; r--) begin
      if (!row_full_q[r]) first_row = ROW_W'(r);
    end
  end

  // flags past the last block count as taken
  always_comb begin
    for (int b = 0; b < ROW_BITS; b++) begin
      pad_mask[b] = (idx_row == ROW_W'(NUM_ROWS - 1)) && (b >= LAST_CNT);
    end
  end

  assign row_taken = row_data | pad_mask;

  always_comb begin
    free_bit = '0;
    for (int b = ROW_BITS - 1; b >= 0; b--) begin
      if (!row_taken[b]) free_bit = ROW_BIT_W'(b);
    end
  end

  assign wr_data  = cmd_i.alloc_wr ? (row_data | (ROW_BITS'(1) << free_bit))
                                   : (row_data & ~(ROW_BITS'(1) << idx_bit));
  assign new_full = &(wr_data | pad_mask);

  assign q_est = BLK_W'(prod_q >> OFF_W);
  assign rem   = off_q - OFF_W'(OFF_W'(q_est) * OFF_W'(BLOCK_BYTES));
  assign q_fix = (rem >= OFF_W'(BLOCK_BYTES)) ? q_est + BLK_W'(1) : q_est;

  assign alloc_addr = base_q + ADDR_W'(ADDR_W'(idx_q) * ADDR_W'(BLOCK_BYTES));
  assign rd_addr    = cmd_i.alloc_rd ? first_row : idx_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= '0;
      row_vld_q  <= '0;
      row_full_q <= '0;
    end else begin
      if (cfg_we_i) base_q <= cfg_data_i;
      if (cmd_i.alloc_wr || cmd_i.free_wr) begin
        row_vld_q[idx_row]  <= 1'b1;
        row_full_q[idx_row] <= new_full;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc_rd || cmd_i.free_rd) begin
      rd_q     <= map_mem[rd_addr];
      rd_vld_q <= row_vld_q[rd_addr];
    end
    if (cmd_i.alloc_wr || cmd_i.free_wr) begin
      map_mem[idx_row] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_req)  req_q  <= req_i;
    if (cmd_i.free_off) off_q  <= offset_full[OFF_W-1:0];
    if (cmd_i.free_mul) prod_q <= PROD_W'(off_q) * PROD_W'(RECIP);
    if (cmd_i.alloc_rd) idx_q  <= {first_row, ROW_BIT_W'(0)};
    else if (cmd_i.alloc_wr) idx_q <= {idx_row, free_bit};
    else if (cmd_i.free_div) idx_q <= q_fix;
    if (cmd_i.res_load) begin
      rsp_q.status <= cmd_i.res_status;
      rsp_q.block_index <= (cmd_i.res_status == ST_ALLOCATED ||
                            cmd_i.res_status == ST_FREED) ? INDEX_OUT_W'(idx_q) : '0;
      rsp_q.block_address <= (cmd_i.res_status == ST_ALLOCATED) ? alloc_addr : '0;
    end
  end

  assign stat_o.op       = req_q.operation;
  assign stat_o.any_free = ~&row_full_q;
  assign stat_o.is_null  = (req_q.free_address == '0);
  assign stat_o.outside  = (offset_full >= ADDR_W'(SPAN));
  assign rsp_o           = rsp_q;

endmodule
